### rtl/llq_pkg.sv
// ----------------------------------------------------------------------------
// llq_pkg
// Shared types and constants for the linked-list queue with a free pool.
// ----------------------------------------------------------------------------
`default_nettype none

package llq_pkg;

   localparam int DEFAULT_POOL_DEPTH = 16;
   localparam int DATA_W             = 32;
   localparam int STATUS_W           = 2;

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_code_type;

endpackage : llq_pkg

`default_nettype wire

### rtl/llq_ram.sv
// ----------------------------------------------------------------------------
// llq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module llq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : llq_ram

`default_nettype wire

### rtl/linked_list_queue_with_free_pool_unit.sv
// ----------------------------------------------------------------------------
// linked_list_queue_with_free_pool_unit
// FIFO queue kept as a linked list in a pool of nodes, with a free list.
// ----------------------------------------------------------------------------
//   Channel  Ports                         Dir  Beat
//   req      req_valid/ready, req_type,    in   enqueue value or dequeue
//            req_value_in
//   rsp      rsp_valid/ready, rsp_status,  out  status and dequeued value
//            rsp_value_out
//
// One beat is accepted per cycle whenever the result register is empty or
// is being drained; the result is registered and appears in the cycle after acceptance.
// The pool RAMs are read ahead at the next head pointers, and a
// same-cycle write to the address being read is forwarded.
// The link RAM needs no clearing pass at reset because nodes never handed
// out are tracked by a watermark.
// A stalled result register holds req_ready low until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_list_queue_with_free_pool_unit
   import llq_pkg::*;
#(
   parameter int POOL_DEPTH = DEFAULT_POOL_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_type,
   input  wire logic [DATA_W-1:0] req_value_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [DATA_W-1:0]      rsp_value_out
);

   localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int LINK_W = $clog2(POOL_DEPTH + 1);
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);
   localparam logic [LINK_W-1:0] TOP_NODE  = LINK_W'(POOL_DEPTH - 1);

   // Queue state.
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic [LINK_W-1:0] free_head_ff, free_head_in;
   // Nodes below this mark were never handed out and still link to index-1.
   logic [LINK_W-1:0] fresh_ff, fresh_in;

   // Result register.
   logic                  rsp_valid_ff;
   status_code_type       rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]     rsp_value_ff, rsp_value_in;

   // RAM write side.
   logic              link_we;
   logic [IDX_W-1:0]  link_wa;
   logic [LINK_W-1:0] link_wd;
   logic              pay_we;
   logic [IDX_W-1:0]  pay_wa;

   // RAM read side and forwarding.
   logic [IDX_W-1:0]  free_rd_addr, front_rd_addr;
   logic [LINK_W-1:0] free_link_ram, front_link_ram;
   logic [DATA_W-1:0] front_pay_ram;
   logic              free_hit_ff, front_hit_ff, pay_hit_ff;
   logic [LINK_W-1:0] link_fwd_ff;
   logic [DATA_W-1:0] pay_fwd_ff;

   logic              accept;
   logic [IDX_W-1:0]  free_idx;
   logic              free_is_fresh;
   logic [LINK_W-1:0] free_next;
   logic [LINK_W-1:0] front_next;
   logic [DATA_W-1:0] front_value;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign free_idx      = free_head_ff[IDX_W-1:0];
   assign free_is_fresh = free_head_ff < fresh_ff;

   always_comb begin
      if (free_is_fresh) begin
         free_next = (free_head_ff == '0) ? NULL_LINK : free_head_ff - LINK_W'(1);
      end else if (free_hit_ff) begin
         free_next = link_fwd_ff;
      end else begin
         free_next = free_link_ram;
      end
   end

   assign front_next  = front_hit_ff ? link_fwd_ff : front_link_ram;
   assign front_value = pay_hit_ff ? pay_fwd_ff : front_pay_ram;

   always_comb begin
      front_in      = front_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      link_we       = 1'b0;
      link_wa       = tail_ff;
      link_wd       = LINK_W'(free_idx);
      pay_we        = 1'b0;
      pay_wa        = free_idx;
      rsp_status_in = STATUS_OK;
      rsp_value_in  = '0;
      if (accept) begin
         case (req_code_type'(req_type))
            REQ_ENQUEUE: begin
               if (free_head_ff == NULL_LINK) begin
                  rsp_status_in = STATUS_OVERFLOW;
               end else begin
                  free_head_in = free_next;
                  if (free_is_fresh) begin
                     fresh_in = free_head_ff;
                  end
                  pay_we = 1'b1;
                  // The tail's own link is never read, so only the old
                  // tail needs a write.
                  if (empty_ff) begin
                     front_in = free_idx;
                  end else begin
                     link_we = 1'b1;
                  end
                  tail_in  = free_idx;
                  empty_in = 1'b0;
               end
            end
            REQ_DEQUEUE: begin
               if (empty_ff) begin
                  rsp_status_in = STATUS_UNDERFLOW;
               end else begin
                  rsp_value_in = front_value;
                  link_we      = 1'b1;
                  link_wa      = front_ff;
                  link_wd      = free_head_ff;
                  free_head_in = LINK_W'(front_ff);
                  if (front_ff == tail_ff) begin
                     empty_in = 1'b1;
                     front_in = '0;
                  end else begin
                     front_in = front_next[IDX_W-1:0];
                  end
               end
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   assign free_rd_addr  = free_head_in[IDX_W-1:0];
   assign front_rd_addr = front_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         free_head_ff <= TOP_NODE;
         fresh_ff     <= NULL_LINK;
         rsp_valid_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
         front_hit_ff <= 1'b0;
         pay_hit_ff   <= 1'b0;
      end else begin
         front_ff     <= front_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         free_hit_ff  <= link_we && (link_wa == free_rd_addr);
         front_hit_ff <= link_we && (link_wa == front_rd_addr);
         pay_hit_ff   <= pay_we && (pay_wa == front_rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      link_fwd_ff <= link_wd;
      pay_fwd_ff  <= req_value_in;
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   // Two copies of the link store give the free-list and the front reads.
   llq_ram #(
      .WIDTH (LINK_W),
      .DEPTH (POOL_DEPTH)
   ) u_free_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (free_rd_addr),
      .rd_data (free_link_ram)
   );

   llq_ram #(
      .WIDTH (LINK_W),
      .DEPTH (POOL_DEPTH)
   ) u_front_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (front_rd_addr),
      .rd_data (front_link_ram)
   );

   llq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (POOL_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_wa),
      .wr_data (req_value_in),
      .rd_addr (front_rd_addr),
      .rd_data (front_pay_ram)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

endmodule : linked_list_queue_with_free_pool_unit

`default_nettype wire

### dv/linked_list_queue_with_free_pool_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_queue_with_free_pool_unit_test
// Self-checking bench for the pooled linked-list queue. Enqueue and dequeue
// beats go through a cycle-free model of the node pool and its free list, and
// each result beat is compared against the oldest predicted result.
// ----------------------------------------------------------------------------
module linked_list_queue_with_free_pool_unit_test
   import llq_pkg::*;
();

   localparam int POOL_DEPTH   = DEFAULT_POOL_DEPTH;
   localparam int IDX_W        = $clog2(POOL_DEPTH);
   localparam int LINK_W       = IDX_W + 1;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_GAP      = 40;
   localparam int MAX_PRINTED  = 40;

   typedef struct packed {
      status_code_type   status;
      logic [DATA_W-1:0] value;
   } queue_result_type;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_type     = REQ_ENQUEUE;
   logic [DATA_W-1:0]   req_value_in = '0;
   logic                rsp_ready    = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_value_out;

   linked_list_queue_with_free_pool_unit #(
      .POOL_DEPTH(POOL_DEPTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_value_in (req_value_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_value_out(rsp_value_out)
   );

   // Mirror of the node pool: payloads, links, list ends and free-list head.
   logic [DATA_W-1:0] pool_data [POOL_DEPTH];
   logic [LINK_W-1:0] pool_link [POOL_DEPTH];
   logic [IDX_W-1:0]  front_node;
   logic [IDX_W-1:0]  tail_node;
   logic              list_empty;
   logic [LINK_W-1:0] free_node;

   queue_result_type pending_results[$];
   int error_count = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_cycles = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   function automatic void clear_pool_model();
      for (int i = 0; i < POOL_DEPTH; i++) begin
         pool_data[i] = '0;
         pool_link[i] = (i == 0) ? NULL_LINK : LINK_W'(i - 1);
      end
      front_node = '0;
      tail_node  = '0;
      list_empty = 1'b1;
      free_node  = LINK_W'(POOL_DEPTH - 1);
   endfunction

   function automatic queue_result_type apply_queue_op(req_code_type op,
                                                       logic [DATA_W-1:0] val);
      queue_result_type  res;
      logic [IDX_W-1:0]  node;
      logic [LINK_W-1:0] next;
      res.status = STATUS_OK;
      res.value  = '0;
      if (op == REQ_ENQUEUE) begin
         if (free_node >= NULL_LINK) begin
            res.status = STATUS_OVERFLOW;
         end else begin
            node = free_node[IDX_W-1:0];
            free_node = pool_link[node];
            pool_data[node] = val;
            pool_link[node] = NULL_LINK;
            if (list_empty) begin
               front_node = node;
            end else begin
               pool_link[tail_node] = {1'b0, node};
            end
            tail_node  = node;
            list_empty = 1'b0;
         end
      end else begin
         if (list_empty) begin
            res.status = STATUS_UNDERFLOW;
         end else begin
            node = front_node;
            next = pool_link[node];
            res.value = pool_data[node];
            pool_link[node] = free_node;
            free_node = {1'b0, node};
            if (next >= NULL_LINK) begin
               list_empty = 1'b1;
               front_node = '0;
            end else begin
               front_node = next[IDX_W-1:0];
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (error_count < MAX_PRINTED)
         $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Offers one beat and returns right after the edge at which it is taken.
   // The valid line is left high so that back-to-back beats need no toggle.
   task automatic send_beat(input req_code_type op, input logic [DATA_W-1:0] val);
      int gap;
      bit taken;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= op;
      req_value_in <= val;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      pending_results.push_back(apply_queue_op(op, val));
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Result side: outputs are stable at the falling edge, so a beat seen
   // there is the one taken at the next rising edge.
   initial begin
      queue_result_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result beat with nothing pending", rsp_value_out, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("rsp_status", DATA_W'(rsp_status), DATA_W'(want.status));
               if (rsp_value_out !== want.value)
                  report_mismatch("rsp_value_out", rsp_value_out, want.value);
            end
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("linked_list_queue_with_free_pool_unit verification failed");
         $finish;
      end
   end

   // Underflow on an empty queue, the extreme payloads, and the queue
   // draining back to empty.
   task automatic test_empty_queue();
      send_beat(REQ_DEQUEUE, '1);
      send_beat(REQ_ENQUEUE, '0);
      send_beat(REQ_ENQUEUE, '1);
      send_beat(REQ_DEQUEUE, '1);
      send_beat(REQ_DEQUEUE, '0);
      send_beat(REQ_DEQUEUE, 32'h5A5A_A5A5);
   endtask

   // Uses every node of the pool, then one more enqueue must overflow.
   task automatic test_full_pool();
      for (int i = 0; i < POOL_DEPTH; i++)
         send_beat(REQ_ENQUEUE, (i % 2) ? ~(32'hA5A5_0000 | i) : (32'hA5A5_0000 | i));
      send_beat(REQ_ENQUEUE, 32'hDEAD_BEEF);
   endtask

   // The receiver holds off long enough that the block stalls its input.
   task automatic test_backpressure_fill();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_cycles = 300;
      for (int i = 0; i < 30; i++)
         send_beat(($urandom_range(1) != 0) ? REQ_DEQUEUE : REQ_ENQUEUE, pick_word());
   endtask

   // Bursts with an enqueue bias that swings between filling and draining,
   // so the pool hits full and empty again and again.
   task automatic run_traffic_phase(input int count);
      int sent;
      int burst;
      int enq_pct;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(2))
            0:       enq_pct = 85;
            1:       enq_pct = 50;
            default: enq_pct = 15;
         endcase
         burst = $urandom_range(8, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_beat(($urandom_range(99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE,
                      pick_word());
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      tx_idle_pct = 10;
      rx_idle_pct = 65;
      run_traffic_phase(600);
      tx_idle_pct = 65;
      rx_idle_pct = 10;
      run_traffic_phase(600);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_traffic_phase(600);
   endtask

   initial begin
      clear_pool_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_full_pool();
      test_backpressure_fill();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("linked_list_queue_with_free_pool_unit verification clean");
      end else begin
         $display("linked_list_queue_with_free_pool_unit verification failed");
      end
      $finish;
   end

endmodule

### linked_list_queue_with_free_pool_unit.f
rtl/llq_pkg.sv
rtl/llq_ram.sv
rtl/linked_list_queue_with_free_pool_unit.sv
dv/linked_list_queue_with_free_pool_unit_test.sv
